// File: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, constants and codes of the scaled monochrome bitmap expander.
// ----------------------------------------------------------------------------
package sme_pkg;

  // Store and fixed-point geometry
  localparam int BITMAP_BYTES = 512;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_W       = $clog2(BITMAP_BYTES);
  localparam int SRC_W        = 7;
  localparam int STEP_W       = FRAC_BITS + SRC_W;
  localparam int DIV_CNT_W    = $clog2(STEP_W + 1);

  // Field widths
  localparam int DST_W      = 12;
  localparam int POS_W      = 12;
  localparam int SUM_W      = POS_W + 1;
  localparam int STRIDE_W   = 13;
  localparam int COLOR_W    = 32;
  localparam int IDX_W      = 25;
  localparam int BYTE_W     = 8;
  localparam int BIDX_W     = 9;
  localparam int BITSEL_W   = 3;
  localparam int BIT_W      = 2 * SRC_W;
  localparam int PROD_W     = POS_W + STEP_W;
  localparam int PIX_FULL_W = SUM_W + STRIDE_W;

  // Port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset values
  localparam logic [SRC_W-1:0]    SRC_WIDTH_RST  = 7'd8;
  localparam logic [SRC_W-1:0]    SRC_HEIGHT_RST = 7'd16;
  localparam logic [DST_W-1:0]    DST_WIDTH_RST  = 12'd8;
  localparam logic [DST_W-1:0]    DST_HEIGHT_RST = 12'd16;
  localparam logic [STRIDE_W-1:0] FB_STRIDE_RST  = 13'd1024;
  localparam logic [COLOR_W-1:0]  DRAW_COLOR_RST = 32'hFFFF_FFFF;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 4'd0,
    REG_SRC_HEIGHT = 4'd1,
    REG_DST_WIDTH  = 4'd2,
    REG_DST_HEIGHT = 4'd3,
    REG_DEST_X     = 4'd4,
    REG_DEST_Y     = 4'd5,
    REG_FB_STRIDE  = 4'd6,
    REG_DRAW_COLOR = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SRC_W-1:0]    src_width;
    logic [SRC_W-1:0]    src_height;
    logic [DST_W-1:0]    dst_width;
    logic [DST_W-1:0]    dst_height;
    logic [POS_W-1:0]    dest_x;
    logic [POS_W-1:0]    dest_y;
    logic [STRIDE_W-1:0] fb_stride;
    logic [COLOR_W-1:0]  draw_color;
  } cfg_regs_t;

  // One classified item waiting for the back end
  typedef struct packed {
    kind_t               kind;
    logic                ok;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [BITSEL_W-1:0] bit_sel;
    logic [IDX_W-1:0]    pix_idx;
  } q_entry_t;

endpackage

// File: hdl/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on we, capture read data on re, hold otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sme_step_div.sv
// ----------------------------------------------------------------------------
// sme_step_div
// Restoring divider for one scaling step: (src << FRAC_BITS) / dst + 1,
// one quotient bit per cycle. A zero divisor is taken as one.
// ----------------------------------------------------------------------------
module sme_step_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sme_pkg::SRC_W-1:0]      src,
  input  logic [sme_pkg::DST_W-1:0]      dst,
  output logic                           busy,
  output logic [sme_pkg::STEP_W-1:0]     step
);

  logic                              pend_r;
  logic                              run_r;
  logic [sme_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [sme_pkg::STEP_W-1:0]        quo_r;
  logic [sme_pkg::DST_W-1:0]         rem_r;
  logic [sme_pkg::STEP_W-1:0]        step_r;

  logic [sme_pkg::DST_W-1:0]         div_d;
  logic [sme_pkg::DST_W:0]           rem_sh;
  logic                              ge;
  logic [sme_pkg::DST_W-1:0]         rem_nxt;
  logic [sme_pkg::STEP_W-1:0]        quo_nxt;
  logic                              load;

  // Divisor, trial subtract and next quotient bit
  always_comb begin
    div_d   = (dst == '0) ? sme_pkg::DST_W'(1) : dst;
    rem_sh  = {rem_r, quo_r[sme_pkg::STEP_W-1]};
    ge      = (rem_sh >= {1'b0, div_d});
    rem_nxt = ge ? sme_pkg::DST_W'(rem_sh - {1'b0, div_d}) : rem_sh[sme_pkg::DST_W-1:0];
    quo_nxt = {quo_r[sme_pkg::STEP_W-2:0], ge};
    load    = pend_r && !start;
  end

  // Control: load once the start request is gone, so new settings are seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      if (start) begin
        pend_r <= 1'b1;
        run_r  <= 1'b0;
      end else if (load) begin
        pend_r <= 1'b0;
        run_r  <= 1'b1;
        cnt_r  <= sme_pkg::DIV_CNT_W'(sme_pkg::STEP_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == sme_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          step_r <= quo_nxt + 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= sme_pkg::STEP_W'(src) << sme_pkg::FRAC_BITS;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = pend_r || run_r;
  assign step = step_r;

endmodule

// File: hdl/sme_front.sv
// ----------------------------------------------------------------------------
// sme_front
// Accepts input transactions, classifies loads and queries and works out
// the store address, bit select and framebuffer index in two stages.
// ----------------------------------------------------------------------------
module sme_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sme_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  sme_pkg::cfg_regs_t                 cfg,
  input  logic [sme_pkg::STEP_W-1:0]         step_x,
  input  logic [sme_pkg::STEP_W-1:0]         step_y,
  input  logic                               step_busy,
  input  logic [sme_pkg::QCNT_W-1:0]         q_count,
  output logic                               q_push,
  output sme_pkg::q_entry_t                  q_entry
);

  localparam int BVAL_LO = sme_pkg::BIDX_W;
  localparam int COL_LO  = BVAL_LO + sme_pkg::BYTE_W;
  localparam int ROW_LO  = COL_LO + sme_pkg::POS_W;

  logic                           acc;
  logic [sme_pkg::BIDX_W-1:0]     bidx;
  logic [sme_pkg::BYTE_W-1:0]     bval;
  logic [sme_pkg::POS_W-1:0]      col;
  logic [sme_pkg::POS_W-1:0]      row;
  logic [sme_pkg::PROD_W-1:0]     prod_x;
  logic [sme_pkg::PROD_W-1:0]     prod_y;
  logic [sme_pkg::QCNT_W:0]       pending;

  // Stage 1 registers
  logic                           f1_v_r;
  sme_pkg::kind_t                 f1_kind_r;
  logic [sme_pkg::BIDX_W-1:0]     f1_bidx_r;
  logic [sme_pkg::BYTE_W-1:0]     f1_bval_r;
  logic [sme_pkg::SRC_W-1:0]      f1_fx_r;
  logic [sme_pkg::SRC_W-1:0]      f1_fy_r;
  logic                           f1_inside_r;
  logic [sme_pkg::SUM_W-1:0]      f1_rsum_r;
  logic [sme_pkg::SUM_W-1:0]      f1_csum_r;

  // Stage 2 signals and registers
  logic [sme_pkg::BIT_W-1:0]      bit_addr;
  logic [sme_pkg::BIT_W-4:0]      byte_addr;
  logic [sme_pkg::PIX_FULL_W-1:0] pix_full;
  sme_pkg::q_entry_t              f2_nxt;
  logic                           f2_v_r;
  sme_pkg::q_entry_t              f2_r;

  // Unpack payload
  always_comb begin
    bidx = in_tdata[sme_pkg::BIDX_W-1:0];
    bval = in_tdata[BVAL_LO +: sme_pkg::BYTE_W];
    col  = in_tdata[COL_LO +: sme_pkg::POS_W];
    row  = in_tdata[ROW_LO +: sme_pkg::POS_W];
  end

  // Admit only while steps are settled and the queue has a slot per item in flight
  always_comb begin
    pending   = (sme_pkg::QCNT_W+1)'(q_count) + (sme_pkg::QCNT_W+1)'(f1_v_r)
              + (sme_pkg::QCNT_W+1)'(f2_v_r);
    in_tready = !step_busy && (pending < (sme_pkg::QCNT_W+1)'(sme_pkg::QDEPTH));
    acc       = in_tvalid && in_tready;
  end

  // Scale the destination position to source coordinates
  assign prod_x = sme_pkg::PROD_W'(col) * sme_pkg::PROD_W'(step_x);
  assign prod_y = sme_pkg::PROD_W'(row) * sme_pkg::PROD_W'(step_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_kind_r   <= sme_pkg::kind_t'(in_tuser);
      f1_bidx_r   <= bidx;
      f1_bval_r   <= bval;
      f1_fx_r     <= prod_x[sme_pkg::FRAC_BITS +: sme_pkg::SRC_W];
      f1_fy_r     <= prod_y[sme_pkg::FRAC_BITS +: sme_pkg::SRC_W];
      f1_inside_r <= (col < cfg.dst_width) && (row < cfg.dst_height);
      f1_rsum_r   <= sme_pkg::SUM_W'(row) + sme_pkg::SUM_W'(cfg.dest_y);
      f1_csum_r   <= sme_pkg::SUM_W'(col) + sme_pkg::SUM_W'(cfg.dest_x);
    end
  end

  // Bit address in the store, framebuffer index, and the queue entry
  always_comb begin
    bit_addr  = sme_pkg::BIT_W'(f1_fy_r) * sme_pkg::BIT_W'(cfg.src_width)
              + sme_pkg::BIT_W'(f1_fx_r);
    byte_addr = bit_addr[sme_pkg::BIT_W-1:3];
    pix_full  = sme_pkg::PIX_FULL_W'(f1_rsum_r) * sme_pkg::PIX_FULL_W'(cfg.fb_stride)
              + sme_pkg::PIX_FULL_W'(f1_csum_r);

    f2_nxt.kind = f1_kind_r;
    f2_nxt.data = f1_bval_r;
    if (f1_kind_r == sme_pkg::KIND_LOAD) begin
      f2_nxt.ok      = (32'(f1_bidx_r) < 32'(sme_pkg::BITMAP_BYTES));
      f2_nxt.addr    = sme_pkg::ADDR_W'(f1_bidx_r);
      f2_nxt.bit_sel = '0;
      f2_nxt.pix_idx = '0;
    end else begin
      f2_nxt.ok      = f1_inside_r && (32'(byte_addr) < 32'(sme_pkg::BITMAP_BYTES));
      f2_nxt.addr    = sme_pkg::ADDR_W'(byte_addr);
      f2_nxt.bit_sel = bit_addr[sme_pkg::BITSEL_W-1:0];
      f2_nxt.pix_idx = pix_full[sme_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_v_r) begin
      f2_r <= f2_nxt;
    end
  end

  assign q_push  = f2_v_r;
  assign q_entry = f2_r;

endmodule

// File: hdl/sme_queue.sv
// ----------------------------------------------------------------------------
// sme_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module sme_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  sme_pkg::q_entry_t             push_entry,
  input  logic                          pop,
  output sme_pkg::q_entry_t             head,
  output logic                          empty,
  output logic [sme_pkg::QCNT_W-1:0]    count
);

  sme_pkg::q_entry_t               slot_r [sme_pkg::QDEPTH];
  logic [sme_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [sme_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [sme_pkg::QCNT_W-1:0]      count_r;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

// File: hdl/sme_back.sv
// ----------------------------------------------------------------------------
// sme_back
// Carries out queued items: loads write the bitmap store, queries read it,
// pick the sampled bit and present the result transaction.
// ----------------------------------------------------------------------------
module sme_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  sme_pkg::q_entry_t                  q_head,
  output logic                               q_pop,
  input  logic [sme_pkg::COLOR_W-1:0]        draw_color,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sme_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  localparam int PAD_W = sme_pkg::OUT_TDATA_W - sme_pkg::IDX_W - sme_pkg::COLOR_W;

  logic                             head_load;
  logic                             ram_we;
  logic                             ram_re;
  logic [sme_pkg::BYTE_W-1:0]       ram_rdata;
  logic                             b1_adv;
  logic                             hit;

  logic                             b1_v_r;
  logic                             b1_v_nxt;
  logic                             b1_ok_r;
  logic [sme_pkg::BITSEL_W-1:0]     b1_bit_sel_r;
  logic [sme_pkg::IDX_W-1:0]        b1_pix_r;

  logic                             o_v_r;
  logic                             o_v_nxt;
  logic                             o_we_r;
  logic [sme_pkg::IDX_W-1:0]        o_idx_r;
  logic [sme_pkg::COLOR_W-1:0]      o_color_r;

  // Pop a load at once; pop a query when the read stage can take it
  always_comb begin
    head_load = (q_head.kind == sme_pkg::KIND_LOAD);
    b1_adv    = b1_v_r && (!o_v_r || out_tready);
    q_pop     = !q_empty && (head_load || !b1_v_r || b1_adv);
    ram_we    = q_pop && head_load && q_head.ok;
    ram_re    = q_pop && !head_load;
    b1_v_nxt  = ram_re || (b1_v_r && !b1_adv);
    o_v_nxt   = b1_adv || (o_v_r && !out_tready);
  end

  sme_ram #(
    .WIDTH (sme_pkg::BYTE_W),
    .DEPTH (sme_pkg::BITMAP_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (q_head.addr),
    .wdata (q_head.data),
    .rdata (ram_rdata)
  );

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      b1_ok_r      <= q_head.ok;
      b1_bit_sel_r <= q_head.bit_sel;
      b1_pix_r     <= q_head.pix_idx;
    end
  end

  // Bit 7 of a byte is the leftmost pixel
  assign hit = b1_ok_r && ram_rdata[sme_pkg::BITSEL_W'(sme_pkg::BYTE_W - 1) - b1_bit_sel_r];

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) begin
      o_we_r    <= hit;
      o_idx_r   <= hit ? b1_pix_r : '0;
      o_color_r <= hit ? draw_color : '0;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_we_r;
  assign out_tdata  = {{PAD_W{1'b0}}, o_color_r, o_idx_r};

endmodule

// File: hdl/scaled_mono_bitmap_expand_unit.sv
// ----------------------------------------------------------------------------
// scaled_mono_bitmap_expand_unit
// Nearest-neighbour scaled expansion of a 1-bit-per-pixel bitmap.
// ----------------------------------------------------------------------------
// Load the bitmap with load transactions (in_tuser 0), one byte each, bit 7
// leftmost, then send query transactions (in_tuser 1) naming a destination
// column and row; each query returns one result: out_tuser is the write flag,
// out_tdata the framebuffer index relative to the base and the colour (both
// zero when nothing is to be written). Loads return nothing. Items of either
// kind are taken at one per cycle while the dividers are idle and the queue
// has room; results leave one per cycle while out_tready is high. The 7.16 x
// and y steps come from a pair of one-bit-per-cycle dividers that run after
// reset and after every configuration write; in_tready stays low until they
// finish. A small queue between the address front end and the store back
// end absorbs output stalls.
// ----------------------------------------------------------------------------
module scaled_mono_bitmap_expand_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [8:0] byte_index, [16:9] byte_value, [28:17] col, [40:29] row, rest zero
  input  logic [sme_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] kind
  input  logic                               in_tuser,
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [24:0] pixel_index, [56:25] pixel_color, rest zero
  output logic [sme_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] write_enable
  output logic                               out_tuser,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sme_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sme_pkg::cfg_regs_t               cfg_r;
  logic                             cfg_wr;
  logic [sme_pkg::STEP_W-1:0]       step_x;
  logic [sme_pkg::STEP_W-1:0]       step_y;
  logic                             busy_x;
  logic                             busy_y;
  logic                             q_push;
  sme_pkg::q_entry_t                q_entry;
  logic                             q_pop;
  sme_pkg::q_entry_t                q_head;
  logic                             q_empty;
  logic [sme_pkg::QCNT_W-1:0]       q_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= sme_pkg::SRC_WIDTH_RST;
      cfg_r.src_height <= sme_pkg::SRC_HEIGHT_RST;
      cfg_r.dst_width  <= sme_pkg::DST_WIDTH_RST;
      cfg_r.dst_height <= sme_pkg::DST_HEIGHT_RST;
      cfg_r.dest_x     <= '0;
      cfg_r.dest_y     <= '0;
      cfg_r.fb_stride  <= sme_pkg::FB_STRIDE_RST;
      cfg_r.draw_color <= sme_pkg::DRAW_COLOR_RST;
    end else if (cfg_wr) begin
      unique case (sme_pkg::cfg_idx_t'(cfg_index))
        sme_pkg::REG_SRC_WIDTH:  cfg_r.src_width  <= cfg_data[sme_pkg::SRC_W-1:0];
        sme_pkg::REG_SRC_HEIGHT: cfg_r.src_height <= cfg_data[sme_pkg::SRC_W-1:0];
        sme_pkg::REG_DST_WIDTH:  cfg_r.dst_width  <= cfg_data[sme_pkg::DST_W-1:0];
        sme_pkg::REG_DST_HEIGHT: cfg_r.dst_height <= cfg_data[sme_pkg::DST_W-1:0];
        sme_pkg::REG_DEST_X:     cfg_r.dest_x     <= cfg_data[sme_pkg::POS_W-1:0];
        sme_pkg::REG_DEST_Y:     cfg_r.dest_y     <= cfg_data[sme_pkg::POS_W-1:0];
        sme_pkg::REG_FB_STRIDE:  cfg_r.fb_stride  <= cfg_data[sme_pkg::STRIDE_W-1:0];
        sme_pkg::REG_DRAW_COLOR: cfg_r.draw_color <= cfg_data[sme_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Step dividers, restarted by every configuration write
  sme_step_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .src   (cfg_r.src_width),
    .dst   (cfg_r.dst_width),
    .busy  (busy_x),
    .step  (step_x)
  );

  sme_step_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .src   (cfg_r.src_height),
    .dst   (cfg_r.dst_height),
    .busy  (busy_y),
    .step  (step_y)
  );

  sme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .step_x    (step_x),
    .step_y    (step_y),
    .step_busy (busy_x || busy_y),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  sme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .count      (q_count)
  );

  sme_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .draw_color (cfg_r.draw_color),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: scaled monochrome bitmap expander bench
// Fills the bitmap store, then runs directed corner queries and randomised
// phases of loads and queries under varying register settings. A scoreboard
// predicts every query result from its own copy of the registers and store
// and checks each output transaction in order. Both stream sides idle at
// random; one phase holds the result side off long enough to back up input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int SETTLE_CYC  = 12;
  localparam int PHASES      = 24;
  localparam int PHASE_ITEMS = 56;
  localparam int PRINT_MAX   = 40;

  // One expected framebuffer write decision
  typedef struct {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pixel_write_t;

  // --------------------------------------------------------------------------
  // Scoreboard: register and store shadow, write predictor, in-order checker
  // --------------------------------------------------------------------------
  class blit_scoreboard;
    cfg_regs_t         regs;
    logic [BYTE_W-1:0] bitmap [BITMAP_BYTES];
    pixel_write_t      pending_writes [$];
    int                errors;

    function new();
      regs.src_width  = SRC_WIDTH_RST;
      regs.src_height = SRC_HEIGHT_RST;
      regs.dst_width  = DST_WIDTH_RST;
      regs.dst_height = DST_HEIGHT_RST;
      regs.dest_x     = '0;
      regs.dest_y     = '0;
      regs.fb_stride  = FB_STRIDE_RST;
      regs.draw_color = DRAW_COLOR_RST;
      foreach (bitmap[i]) bitmap[i] = '0;
      errors = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    // Mirror a register write; indexes past the last register are dropped
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  regs.src_width  = data[SRC_W-1:0];
        REG_SRC_HEIGHT: regs.src_height = data[SRC_W-1:0];
        REG_DST_WIDTH:  regs.dst_width  = data[DST_W-1:0];
        REG_DST_HEIGHT: regs.dst_height = data[DST_W-1:0];
        REG_DEST_X:     regs.dest_x     = data[POS_W-1:0];
        REG_DEST_Y:     regs.dest_y     = data[POS_W-1:0];
        REG_FB_STRIDE:  regs.fb_stride  = data[STRIDE_W-1:0];
        REG_DRAW_COLOR: regs.draw_color = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // 7.16 step; a zero destination size divides by one
    function logic [STEP_W-1:0] scale_step(logic [SRC_W-1:0] src, logic [DST_W-1:0] dst);
      logic [STEP_W-1:0] num;
      logic [STEP_W-1:0] den;
      num = {src, {FRAC_BITS{1'b0}}};
      den = (dst == '0) ? STEP_W'(1) : STEP_W'(dst);
      return num / den + STEP_W'(1);
    endfunction

    // Store a load, or predict the write decision of a query
    function void note_item(kind_t kind, logic [IN_TDATA_W-1:0] d);
      logic [BIDX_W-1:0] bidx;
      logic [BYTE_W-1:0] bval;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic [63:0]       fx;
      logic [63:0]       fy;
      logic [63:0]       bit_addr;
      logic [63:0]       byte_addr;
      logic [63:0]       pix;
      logic              hit;
      pixel_write_t      w;
      bidx = d[8:0];
      bval = d[16:9];
      col  = d[28:17];
      row  = d[40:29];
      if (kind == KIND_LOAD) begin
        if (bidx < BITMAP_BYTES) bitmap[bidx] = bval;
        return;
      end
      step_x = scale_step(regs.src_width, regs.dst_width);
      step_y = scale_step(regs.src_height, regs.dst_height);
      hit = 1'b0;
      if (col < regs.dst_width && row < regs.dst_height) begin
        fx = (64'(col) * 64'(step_x)) >> FRAC_BITS;
        fy = (64'(row) * 64'(step_y)) >> FRAC_BITS;
        // a column that reaches the source width spills into the next row
        bit_addr  = fy * 64'(regs.src_width) + fx;
        byte_addr = bit_addr >> 3;
        // sampling past the end of the store reads as clear
        if (byte_addr < BITMAP_BYTES)
          hit = bitmap[byte_addr[BIDX_W-1:0]][3'd7 - bit_addr[2:0]];
      end
      if (hit) begin
        pix = (64'(row) + 64'(regs.dest_y)) * 64'(regs.fb_stride)
            + (64'(col) + 64'(regs.dest_x));
        w.we    = 1'b1;
        w.idx   = pix[IDX_W-1:0];
        w.color = regs.draw_color;
      end else begin
        w.we    = 1'b0;
        w.idx   = '0;
        w.color = '0;
      end
      pending_writes.push_back(w);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_write(logic we, logic [OUT_TDATA_W-1:0] d);
      pixel_write_t w;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected result we=%0b idx=%0h", we, d[24:0]));
        return;
      end
      w = pending_writes.pop_front();
      if (we !== w.we)
        report($sformatf("write_enable %0b, expected %0b", we, w.we));
      if (d[24:0] !== w.idx)
        report($sformatf("pixel_index %0h, expected %0h", d[24:0], w.idx));
      if (d[56:25] !== w.color)
        report($sformatf("pixel_color %0h, expected %0h", d[56:25], w.color));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  blit_scoreboard sb;
  bit             no_gaps;
  int             rx_hold_req;

  scaled_mono_bitmap_expand_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every transaction at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_item(kind_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check_write(out_tuser, out_tdata);
    end
  end

  // Gap lengths: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    out_tready = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 30) stall_left = gap_len();
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  // Offer one item and hold it until the transaction completes
  task automatic send_item(input kind_t kind, input logic [BIDX_W-1:0] bidx,
                           input logic [BYTE_W-1:0] bval, input logic [POS_W-1:0] col,
                           input logic [POS_W-1:0] row);
    int gap;
    gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {7'd0, row, col, bval, bidx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_query(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
    send_item(KIND_QUERY, BIDX_W'($urandom), BYTE_W'($urandom), col, row);
  endtask

  task automatic send_load(input logic [BIDX_W-1:0] bidx, input logic [BYTE_W-1:0] bval);
    send_item(KIND_LOAD, bidx, bval, POS_W'($urandom), POS_W'($urandom));
  endtask

  // One register write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Register write with junk sometimes above the field
  task automatic write_field(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0 && width < CFG_DATA_W) ? ($urandom << width) : '0;
    write_reg(idx, val | junk);
  endtask

  // Stop offering, wait for every outstanding result, then let loads settle
  task automatic wait_idle();
    int guard;
    in_tvalid = 1'b0;
    guard     = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Random settings with the extremes weighted in
  task automatic random_config();
    int r;
    r = $urandom_range(0, 9);
    write_field(REG_SRC_WIDTH, (r == 0) ? 1 : (r == 1) ? 64 : (r == 2) ? $urandom_range(0, 127)
                : $urandom_range(1, 64), SRC_W);
    r = $urandom_range(0, 9);
    write_field(REG_SRC_HEIGHT, (r == 0) ? 1 : (r == 1) ? 64 : (r == 2) ? $urandom_range(0, 127)
                : $urandom_range(1, 64), SRC_W);
    r = $urandom_range(0, 19);
    write_field(REG_DST_WIDTH, (r == 0) ? 0 : (r < 3) ? 4095 : (r < 5) ? 1
                : (r < 7) ? $urandom_range(1, 4095) : $urandom_range(1, 96), DST_W);
    r = $urandom_range(0, 19);
    write_field(REG_DST_HEIGHT, (r == 0) ? 0 : (r < 3) ? 4095 : (r < 5) ? 1
                : (r < 7) ? $urandom_range(1, 4095) : $urandom_range(1, 96), DST_W);
    r = $urandom_range(0, 9);
    write_field(REG_DEST_X, (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095), POS_W);
    r = $urandom_range(0, 9);
    write_field(REG_DEST_Y, (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095), POS_W);
    r = $urandom_range(0, 9);
    write_field(REG_FB_STRIDE, (r == 0) ? 1 : (r == 1) ? 4096 : (r == 2) ? 8191
                : $urandom_range(1, 4096), STRIDE_W);
    r = $urandom_range(0, 9);
    write_field(REG_DRAW_COLOR, (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom, COLOR_W);
    // an index past the last register must change nothing
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'(REG_DRAW_COLOR + $urandom_range(1, 8)), $urandom);
  endtask

  // Mostly inside the rectangle, some on the edge, some anywhere
  function automatic logic [POS_W-1:0] pick_coord(logic [DST_W-1:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim != 0 && r < 80) return POS_W'($urandom_range(0, lim - 1));
    if (r < 90) return POS_W'(lim + $urandom_range(0, 2));
    return POS_W'($urandom);
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 99) < 15)
      send_load(BIDX_W'($urandom), BYTE_W'($urandom));
    else
      send_query(pick_coord(sb.regs.dst_width), pick_coord(sb.regs.dst_height));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    no_gaps     = 1'b0;
    rx_hold_req = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole store so that no sample reads an unwritten byte
    for (int a = 0; a < BITMAP_BYTES; a++) send_load(BIDX_W'(a), BYTE_W'($urandom));

    // Reset settings: corners, edges just outside, all-ones coordinates
    send_load(9'd0, 8'hFF);
    send_load(9'd15, 8'h01);
    send_load(9'd511, 8'h80);
    send_query(12'd0, 12'd0);
    send_query(12'd7, 12'd15);
    send_query(12'd8, 12'd0);
    send_query(12'd0, 12'd16);
    send_query(12'd4095, 12'd4095);
    wait_idle();

    // Largest sizes: index wrap-around and samples past the store end
    write_reg(REG_SRC_WIDTH, 64);
    write_reg(REG_SRC_HEIGHT, 64);
    write_reg(REG_DST_WIDTH, 4095);
    write_reg(REG_DST_HEIGHT, 4095);
    write_reg(REG_DEST_X, 4095);
    write_reg(REG_DEST_Y, 4095);
    write_reg(REG_FB_STRIDE, 8191);
    write_reg(REG_DRAW_COLOR, 32'h0);
    send_load(9'd511, 8'hFF);
    send_query(12'd4092, 12'd4029);
    send_query(12'd4094, 12'd4094);
    send_query(12'd0, 12'd0);
    wait_idle();

    // Zero destination size: nothing is ever inside
    write_reg(REG_DST_WIDTH, 0);
    write_reg(REG_DST_HEIGHT, 0);
    send_query(12'd0, 12'd0);
    send_query(12'd4095, 12'd0);
    wait_idle();

    // One-pixel source stretched wide: the column spills into the next row
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_SRC_HEIGHT, 1);
    write_reg(REG_DST_WIDTH, 4095);
    write_reg(REG_DST_HEIGHT, 1);
    write_reg(REG_DEST_X, 0);
    write_reg(REG_DEST_Y, 0);
    write_reg(REG_FB_STRIDE, 1);
    write_reg(REG_DRAW_COLOR, 32'h5A5A_C3C3);
    write_reg(CFG_IDX_W'(REG_DRAW_COLOR + 1), 32'h0);
    write_reg({CFG_IDX_W{1'b1}}, 32'h0);
    send_query(12'd0, 12'd0);
    send_query(12'd4094, 12'd0);
    wait_idle();

    // Hold the result side off while input keeps coming back to back
    random_config();
    no_gaps     = 1'b1;
    rx_hold_req = 300;
    for (int i = 0; i < 40; i++) send_random_item();
    no_gaps = 1'b0;
    wait_idle();

    // Random phases, some without any idling
    for (int p = 0; p < PHASES; p++) begin
      random_config();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      no_gaps = 1'b0;
      wait_idle();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
